### hdl/tfpd_pkg.sv
// ----------------------------------------------------------------------------
// tfpd_pkg
// Shared constants, widths and command types for the tilt PD motor drive.
// ----------------------------------------------------------------------------
package tfpd_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int AtanEntries        = 24;
    localparam int CordicW            = 36;
    localparam int AngleW             = 34;

    localparam logic signed [AngleW-1:0] QuarterTurn = 34'sd5898674;

    localparam logic [2:0] RegGainP   = 3'd0;
    localparam logic [2:0] RegGainD   = 3'd1;
    localparam logic [2:0] RegBeta    = 3'd2;
    localparam logic [2:0] RegPeriod  = 3'd3;
    localparam logic [2:0] RegOffset  = 3'd4;

    typedef struct packed {
        logic load;
        logic step;
        logic filt;
        logic mix;
    } t_cmd;

    function automatic logic signed [AngleW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [AngleW-1:0] v;
        begin
            unique case (idx)
                5'd0:  v = 34'sd2949337;
                5'd1:  v = 34'sd1741095;
                5'd2:  v = 34'sd919947;
                5'd3:  v = 34'sd466979;
                5'd4:  v = 34'sd234396;
                5'd5:  v = 34'sd117312;
                5'd6:  v = 34'sd58670;
                5'd7:  v = 34'sd29337;
                5'd8:  v = 34'sd14669;
                5'd9:  v = 34'sd7334;
                5'd10: v = 34'sd3667;
                5'd11: v = 34'sd1834;
                5'd12: v = 34'sd917;
                5'd13: v = 34'sd458;
                5'd14: v = 34'sd229;
                5'd15: v = 34'sd115;
                5'd16: v = 34'sd57;
                5'd17: v = 34'sd29;
                5'd18: v = 34'sd14;
                5'd19: v = 34'sd7;
                5'd20: v = 34'sd4;
                5'd21: v = 34'sd2;
                5'd22: v = 34'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

### hdl/tfpd_ctrl.sv
// ----------------------------------------------------------------------------
// tfpd_ctrl
// Sequencer: load, CORDIC iterations, filter update, optional mix output.
// ----------------------------------------------------------------------------
module tfpd_ctrl #(
    parameter int CORDIC_STEPS = tfpd_pkg::CordicStepsDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_emit,
    input  logic           i_out_busy,
    output tfpd_pkg::t_cmd o_cmd
);

    localparam int NSteps = (CORDIC_STEPS < tfpd_pkg::AtanEntries) ?
                            CORDIC_STEPS : tfpd_pkg::AtanEntries;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StIter = 2'd1;
    localparam logic [1:0] StFilt = 2'd2;
    localparam logic [1:0] StMix  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    assign o_ready = (r_state == StIdle);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            StIdle: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = StIter;
                end
            end
            StIter: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 5'd1;
                if (r_cnt == 5'(NSteps - 1)) begin
                    n_state = StFilt;
                end
            end
            StFilt: begin
                o_cmd.filt = 1'b1;
                n_state    = StMix;
            end
            StMix: begin
                if (!i_emit) begin
                    n_state = StIdle;
                end else if (!i_out_busy) begin
                    o_cmd.mix = 1'b1;
                    n_state   = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### hdl/tfpd_dp.sv
// ----------------------------------------------------------------------------
// tfpd_dp
// Datapath: CORDIC vectoring unit, complementary filters, PD mix and drive.
// ----------------------------------------------------------------------------
module tfpd_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tfpd_pkg::t_cmd     i_cmd,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_y,
    input  logic [15:0]        i_gain_p,
    input  logic [15:0]        i_gain_d,
    input  logic [15:0]        i_beta,
    input  logic [3:0]         i_period,
    input  logic signed [8:0]  i_offset,
    output logic               o_emit,
    output logic               o_out_busy,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_drive_a,
    output logic [7:0]         o_drive_b,
    output logic               o_tilt_positive
);

    localparam int W  = tfpd_pkg::CordicW;
    localparam int AW = tfpd_pkg::AngleW;

    logic signed [W-1:0]  r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic [4:0]           r_i;
    logic                 r_zero;
    logic signed [15:0]   r_gy;
    logic signed [31:0]   r_tilt, r_gang;
    logic [3:0]           r_tick;
    logic                 r_valid;
    logic [7:0]           r_a, r_b;
    logic                 r_pos;

    logic signed [16:0] ys0, xs0;
    logic signed [W-1:0] xsh, ysh;
    logic signed [AW-1:0] atn;

    always_comb begin
        ys0 = -17'(i_accel_z);
        xs0 = -17'(i_accel_x);
        xsh = r_x >>> r_i;
        ysh = r_y >>> r_i;
        atn = tfpd_pkg::atan_entry(r_i);
    end

    // Filter arithmetic.
    logic signed [AW+1:0] cur;
    logic signed [49:0]   acc_t, acc_g;
    logic signed [33:0]   sh_t, sh_g;
    logic signed [32:0]   gsum;
    logic signed [31:0]   n_tilt, n_gang;

    always_comb begin
        cur   = (r_zero ? 36'sd0 : 36'(r_z)) + 36'(signed'({i_offset, 16'h0000}));
        acc_t = 50'(signed'({1'b0, i_beta})) * 50'(r_tilt)
              + 50'(signed'(18'h10000 - {2'b00, i_beta})) * 50'(cur);
        sh_t  = 34'((acc_t + 50'sd32768) >>> 16);
        gsum  = 33'(r_gang) + 33'(r_gy);
        acc_g = 50'(signed'({1'b0, i_beta})) * 50'(gsum) + 50'sd32768;
        sh_g  = 34'(acc_g >>> 16);
        n_tilt = (sh_t > 34'sd2147483647) ? 32'h7fffffff :
                 (sh_t < -34'sd2147483648) ? 32'h80000000 : 32'(sh_t);
        n_gang = (sh_g > 34'sd2147483647) ? 32'h7fffffff :
                 (sh_g < -34'sd2147483648) ? 32'h80000000 : 32'(sh_g);
    end

    // Mix and drive.
    logic signed [49:0] mixv;
    logic signed [49:0] lim;
    logic signed [49:0] tmp;
    logic [7:0]         da, db;
    logic               pos;

    always_comb begin
        mixv = 50'(signed'({1'b0, i_gain_p})) * 50'(r_tilt)
             + 50'(signed'({1'b0, i_gain_d})) * 50'(r_gang);
        lim  = 50'sd252 <<< 24;
        pos  = mixv > 50'sd0;
        if (!pos) begin
            tmp = (mixv < -lim) ? -lim : mixv;
            tmp = ((50'sd255 <<< 24) + tmp) >>> 24;
            da  = tmp[7:0];
            db  = 8'd255;
        end else begin
            tmp = (mixv > lim) ? lim : mixv;
            tmp = ((50'sd255 <<< 24) - tmp) >>> 24;
            da  = 8'd255;
            db  = tmp[7:0];
        end
    end

    logic [3:0] tick_inc;
    assign tick_inc = r_tick + 4'd1;
    assign o_emit     = !(r_tick < i_period) || (r_tick == 4'd0 && i_period == 4'd0);
    assign o_out_busy = r_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gy   <= i_gyro_y;
            r_i    <= '0;
            r_zero <= (i_accel_x == 16'sd0) && (i_accel_z == 16'sd0);
            if (xs0 < 0) begin
                if (ys0 >= 0) begin
                    r_x <= W'(ys0) <<< 14;
                    r_y <= W'(-xs0) <<< 14;
                    r_z <= tfpd_pkg::QuarterTurn;
                end else begin
                    r_x <= W'(-ys0) <<< 14;
                    r_y <= W'(xs0) <<< 14;
                    r_z <= -tfpd_pkg::QuarterTurn;
                end
            end else begin
                r_x <= W'(xs0) <<< 14;
                r_y <= W'(ys0) <<< 14;
                r_z <= '0;
            end
        end else if (i_cmd.step) begin
            r_i <= r_i + 5'd1;
            if (r_y >= 0) begin
                r_x <= r_x + ysh;
                r_y <= r_y - xsh;
                r_z <= r_z + atn;
            end else begin
                r_x <= r_x - ysh;
                r_y <= r_y + xsh;
                r_z <= r_z - atn;
            end
        end
        if (i_cmd.mix) begin
            r_a   <= da;
            r_b   <= db;
            r_pos <= pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt  <= '0;
            r_gang  <= '0;
            r_tick  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.filt) begin
                r_tilt <= n_tilt;
                r_gang <= n_gang;
                r_tick <= tick_inc;
            end
            if (i_cmd.mix) begin
                r_valid <= 1'b1;
                r_tick  <= '0;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_drive_a       = r_a;
    assign o_drive_b       = r_b;
    assign o_tilt_positive = r_pos;

endmodule

### hdl/tilt_fusion_pd_motor_drive.sv
// ----------------------------------------------------------------------------
// tilt_fusion_pd_motor_drive
// Complementary tilt filter with PD mix and brake-style two-channel drive.
// ----------------------------------------------------------------------------
// Each accepted IMU beat runs through a load step, CORDIC_STEPS vectoring
// iterations (capped at 24) on a single shared shift-add unit, a filter
// update and an output decision; o_ready is high only in idle. The output
// decision waits while a previous result beat is still held on the output.
// A result beat is produced every r_period input beats (every beat at 0).
module tilt_fusion_pd_motor_drive #(
    parameter int CORDIC_STEPS = tfpd_pkg::CordicStepsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_drive_a,
    output logic [7:0]         o_drive_b,
    output logic               o_tilt_positive,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    logic [15:0]       r_gain_p, r_gain_d, r_beta;
    logic [3:0]        r_period;
    logic signed [8:0] r_offset;
    tfpd_pkg::t_cmd    cmd;
    logic              emit, out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= 16'd5632;
            r_gain_d <= 16'd8448;
            r_beta   <= 16'd64749;
            r_period <= 4'd3;
            r_offset <= 9'sd6;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tfpd_pkg::RegGainP:  r_gain_p <= i_cfg_data;
                tfpd_pkg::RegGainD:  r_gain_d <= i_cfg_data;
                tfpd_pkg::RegBeta:   r_beta   <= i_cfg_data;
                tfpd_pkg::RegPeriod: r_period <= i_cfg_data[3:0];
                tfpd_pkg::RegOffset: r_offset <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    tfpd_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_emit     (emit),
        .i_out_busy (out_busy),
        .o_cmd      (cmd)
    );

    tfpd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_accel_x       (i_accel_x),
        .i_accel_z       (i_accel_z),
        .i_gyro_y        (i_gyro_y),
        .i_gain_p        (r_gain_p),
        .i_gain_d        (r_gain_d),
        .i_beta          (r_beta),
        .i_period        (r_period),
        .i_offset        (r_offset),
        .o_emit          (emit),
        .o_out_busy      (out_busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_drive_a       (o_drive_a),
        .o_drive_b       (o_drive_b),
        .o_tilt_positive (o_tilt_positive)
    );

endmodule
